// ===== hw/rtl/wmm_pkg.sv =====
// Package with types, constants and state codes for the window min/max peak tracker.
package wmm_pkg;

    localparam int WINDOW_DEPTH = 128;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SAMPLE_W     = 12;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd100;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                command;
        logic [SAMPLE_W-1:0] sample;
    } in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] latest_sample;
        logic [SAMPLE_W-1:0] window_max;
        logic [SAMPLE_W-1:0] window_min;
        logic [SAMPLE_W-1:0] peak_value;
        logic                measure_enable;
    } out_t;

endpackage

// ===== hw/rtl/window_min_max_peak_tracker_core.sv =====
// Top level of the window min/max peak tracker: history RAM, window scan and result register.
//
// Each accepted transfer (a new sample or a clear-peak command) passes through these steps in
// order: accept and write the sample, one read of the history RAM per window entry through its
// single read port, a step for the last read data, and a load of the result register, which
// waits while an earlier result has not been taken. The next transfer is accepted as soon as the
// result is loaded, even if it has not been taken yet. History entries never written since reset
// read as zero through per-entry valid bits, so the block needs no clearing pass and is ready
// right after reset. The threshold register may be written at any time the block is idle.
module window_min_max_peak_tracker_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  wmm_pkg::in_t           s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output wmm_pkg::out_t          m_data,
    input  logic                   cfg_wr_en,
    input  logic [wmm_pkg::SAMPLE_W-1:0] cfg_wr_data
);

    import wmm_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [PTR_W-1:0]      wptr_reg, wptr_next;
    logic [WINDOW_DEPTH-1:0] valid_reg, valid_next;
    logic                  pend_reg, pend_next;
    logic                  vbit_reg, vbit_next;
    logic [SAMPLE_W-1:0]   hi_reg, hi_next;
    logic [SAMPLE_W-1:0]   lo_reg, lo_next;
    logic [SAMPLE_W-1:0]   peak_reg, peak_next;
    logic [SAMPLE_W-1:0]   latest_reg, latest_next;
    logic                  enable_reg, enable_next;
    logic [SAMPLE_W-1:0]   thresh_reg, thresh_next;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg, m_data_next;

    logic                  ram_we;
    logic [PTR_W-1:0]      ram_raddr;
    logic [SAMPLE_W-1:0]   ram_rdata;
    logic [SAMPLE_W-1:0]   entry;
    logic                  accept;

    wmm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wptr_reg),
        .wr_data (s_data.sample),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign ram_we    = accept && (s_data.command == CMD_SAMPLE);
    assign ram_raddr = cnt_reg[PTR_W-1:0];
    // Entries never written since reset count as zero samples.
    assign entry     = vbit_reg ? ram_rdata : '0;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        wptr_next    = wptr_reg;
        valid_next   = valid_reg;
        pend_next    = 1'b0;
        vbit_next    = valid_reg[cnt_reg[PTR_W-1:0]];
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        peak_next    = peak_reg;
        latest_next  = latest_reg;
        enable_next  = enable_reg;
        thresh_next  = cfg_wr_en ? cfg_wr_data : thresh_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (pend_reg) begin
            if (entry > hi_reg) begin
                hi_next = entry;
            end
            if (entry < lo_reg) begin
                lo_next = entry;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next   = '0;
                    hi_next    = '0;
                    lo_next    = '1;
                    state_next = ST_SCAN;
                    if (s_data.command == CMD_SAMPLE) begin
                        valid_next[wptr_reg] = 1'b1;
                        wptr_next = (wptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                           : wptr_reg + 1'b1;
                        if (s_data.sample > peak_reg) begin
                            peak_next = s_data.sample;
                        end
                        latest_next = s_data.sample;
                        enable_next = (s_data.sample > thresh_reg);
                    end else begin
                        peak_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                pend_next = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WINDOW_DEPTH - 1)) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.latest_sample   = latest_reg;
                    m_data_next.window_max      = hi_reg;
                    m_data_next.window_min      = lo_reg;
                    m_data_next.peak_value      = peak_reg;
                    m_data_next.measure_enable  = enable_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            wptr_reg    <= '0;
            valid_reg   <= '0;
            pend_reg    <= 1'b0;
            peak_reg    <= '0;
            latest_reg  <= '0;
            enable_reg  <= 1'b0;
            thresh_reg  <= THRESHOLD_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            wptr_reg    <= wptr_next;
            valid_reg   <= valid_next;
            pend_reg    <= pend_next;
            peak_reg    <= peak_next;
            latest_reg  <= latest_next;
            enable_reg  <= enable_next;
            thresh_reg  <= thresh_next;
            m_valid_reg <= m_valid_next;
        end
        vbit_reg   <= vbit_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        m_data_reg <= m_data_next;
    end

    // The window always contains the latest sample, so it lies between min and max.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.window_max >= m_data.latest_sample) &&
                    (m_data.latest_sample >= m_data.window_min))
        else $error("latest sample outside window min/max");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.command == CMD_CLEAR)) |=> (peak_reg == '0) && $stable(wptr_reg))
        else $error("clear command did not clear peak or moved write pointer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.command == CMD_SAMPLE)) |=>
            (latest_reg == $past(s_data.sample)) && (peak_reg >= latest_reg))
        else $error("sample not captured or peak below latest sample");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !ram_we)
        else $error("history written during window scan");

endmodule

// ===== hw/rtl/wmm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module wmm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== dv/window_min_max_peak_tracker_checker.sv =====
// Checker for the window min/max peak tracker: tracks the window and compares every result.
module window_min_max_peak_tracker_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  wmm_pkg::in_t                 s_data,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  wmm_pkg::out_t                m_data,
    input  logic                         cfg_wr_en,
    input  logic [wmm_pkg::SAMPLE_W-1:0] cfg_wr_data,
    output int unsigned                  mismatch_count,
    output int unsigned                  pending_count
);
    import wmm_pkg::*;

    localparam int REPORT_LIMIT = 40;

    logic [SAMPLE_W-1:0] history [WINDOW_DEPTH];
    int                  next_slot;
    logic [SAMPLE_W-1:0] peak_hold;
    logic                above_threshold;
    logic [SAMPLE_W-1:0] threshold;
    out_t                window_report_q [$];
    int unsigned         errors;

    function automatic out_t track_item(input in_t item);
        out_t                report;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] lo;
        if (item.command == CMD_SAMPLE) begin
            history[next_slot] = item.sample;
            next_slot = (next_slot + 1) % WINDOW_DEPTH;
            if (item.sample > peak_hold) begin
                peak_hold = item.sample;
            end
            above_threshold = (item.sample > threshold);
        end else begin
            // A clear leaves the window and the threshold flag alone.
            peak_hold = '0;
        end
        hi = history[0];
        lo = history[0];
        for (int k = 1; k < WINDOW_DEPTH; k++) begin
            if (history[k] > hi) begin
                hi = history[k];
            end
            if (history[k] < lo) begin
                lo = history[k];
            end
        end
        report.latest_sample  = history[(next_slot + WINDOW_DEPTH - 1) % WINDOW_DEPTH];
        report.window_max     = hi;
        report.window_min     = lo;
        report.peak_value     = peak_hold;
        report.measure_enable = above_threshold;
        return report;
    endfunction

    function automatic bit field_differs(input string name, input logic [SAMPLE_W-1:0] want,
                                         input logic [SAMPLE_W-1:0] got);
        if (want === got) begin
            return 1'b0;
        end
        if (errors < REPORT_LIMIT) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        bit   bad;
        if (!aresetn) begin
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                history[k] = '0;
            end
            next_slot       = 0;
            peak_hold       = '0;
            above_threshold = 1'b0;
            threshold       = THRESHOLD_RESET;
            errors          = 0;
            window_report_q.delete();
        end else begin
            // A result is registered only after the window scan of its transfer, so a result never
            // belongs to the transfer accepted at the same edge.
            if (m_valid && m_ready) begin
                if (window_report_q.size() == 0) begin
                    if (errors < REPORT_LIMIT) begin
                        $display("%0t: result with no transfer pending: expected none, actual %h",
                                 $time, m_data);
                    end
                    errors++;
                end else begin
                    want = window_report_q.pop_front();
                    bad  = 1'b0;
                    bad |= field_differs("latest_sample", want.latest_sample, m_data.latest_sample);
                    bad |= field_differs("window_max", want.window_max, m_data.window_max);
                    bad |= field_differs("window_min", want.window_min, m_data.window_min);
                    bad |= field_differs("peak_value", want.peak_value, m_data.peak_value);
                    bad |= field_differs("measure_enable", SAMPLE_W'(want.measure_enable),
                                         SAMPLE_W'(m_data.measure_enable));
                    if (bad) begin
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) begin
                threshold = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                window_report_q.push_back(track_item(s_data));
            end
        end
        mismatch_count <= errors;
        pending_count  <= window_report_q.size();
    end

endmodule

// ===== dv/window_min_max_peak_tracker_core_tb.sv =====
// Testbench top for the window min/max peak tracker: clock, reset, stimulus and verdict.
module window_min_max_peak_tracker_core_tb;
    import wmm_pkg::*;

    localparam int RANDOM_ITEMS    = 680;
    localparam int PHASES          = 5;
    localparam int ITEM_CYCLES     = WINDOW_DEPTH + 3;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int WATCHDOG_LIMIT  = 8000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_t                 s_data;
    logic                m_valid;
    logic                m_ready;
    out_t                m_data;
    logic                cfg_wr_en;
    logic [SAMPLE_W-1:0] cfg_wr_data;
    int unsigned         mismatch_count;
    int unsigned         pending_count;
    bit                  hold_off_req;
    bit                  hold_off_done;
    int unsigned         quiet_cycles;

    window_min_max_peak_tracker_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    window_min_max_peak_tracker_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Mostly no gap or a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 30);
        end
        return $urandom_range(100, 400);
    endfunction

    task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] value);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{command: cmd, sample: value};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        // One edge first, so the count includes the transfer accepted at this edge.
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [SAMPLE_W-1:0] value);
        wait_until_drained();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [SAMPLE_W-1:0] thresh;
        int                  band_lo;
        int                  band_hi;
        int                  near;
        int unsigned         roll;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        hold_off_req = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, threshold at its reset value first.
        send_item(CMD_CLEAR, 12'd0);
        send_item(CMD_SAMPLE, 12'd0);
        send_item(CMD_SAMPLE, 12'd4095);
        send_item(CMD_SAMPLE, 12'd100);
        send_item(CMD_SAMPLE, 12'd101);
        send_item(CMD_CLEAR, 12'd4095);
        send_item(CMD_SAMPLE, 12'd50);
        send_item(CMD_SAMPLE, 12'd49);
        send_item(CMD_SAMPLE, 12'd50);
        send_item(CMD_CLEAR, 12'hAAA);
        send_item(CMD_CLEAR, 12'h555);
        send_item(CMD_SAMPLE, 12'd4094);
        send_item(CMD_SAMPLE, 12'd1);
        send_item(CMD_SAMPLE, 12'h555);
        send_item(CMD_SAMPLE, 12'hAAA);
        write_threshold(12'd0);
        send_item(CMD_SAMPLE, 12'd0);
        send_item(CMD_SAMPLE, 12'd1);
        send_item(CMD_CLEAR, 12'd0);
        write_threshold(12'd4095);
        send_item(CMD_SAMPLE, 12'd4095);
        send_item(CMD_SAMPLE, 12'd4094);
        send_item(CMD_CLEAR, 12'd4095);

        band_lo = 0;
        band_hi = 4095;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: begin
                    thresh = '0;
                end
                2: begin
                    thresh = '1;
                end
                3: begin
                    thresh = THRESHOLD_RESET;
                end
                default: begin
                    thresh = SAMPLE_W'($urandom_range(0, 4095));
                end
            endcase
            write_threshold(thresh);
            // The long hold-off starts well inside the first random phase, while items flow.
            if (phase == 0) begin
                hold_off_req = 1'b1;
            end
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                // A narrow band of values now and then lets the window minimum climb and fall.
                if (n % 40 == 0) begin
                    if ($urandom_range(0, 9) < 3) begin
                        band_lo = 0;
                        band_hi = 4095;
                    end else begin
                        band_lo = $urandom_range(0, 4095);
                        band_hi = band_lo + $urandom_range(16, 512);
                        if (band_hi > 4095) begin
                            band_hi = 4095;
                        end
                    end
                end
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    send_item(CMD_CLEAR, SAMPLE_W'($urandom_range(0, 4095)));
                end else if (roll < 18) begin
                    near = int'(thresh) + int'($urandom_range(0, 2)) - 1;
                    if (near < 0) begin
                        near = 0;
                    end
                    if (near > 4095) begin
                        near = 4095;
                    end
                    send_item(CMD_SAMPLE, SAMPLE_W'(near));
                end else begin
                    send_item(CMD_SAMPLE, SAMPLE_W'($urandom_range(band_lo, band_hi)));
                end
            end
        end

        wait_until_drained();
        repeat (2 * ITEM_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Result side: random stalls, long ready stretches and one long hold-off.
    initial begin
        int unsigned gap;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_done = 1'b1;
            end
            gap = pick_gap();
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(500, 3000)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 200)) @(posedge aclk);
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule
